### hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU slot table: field widths, command
// codes, register map and the layout of one slot in the slot memory.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int CMD_W   = 2;
	localparam int KEY_W   = 16;
	localparam int HITS_W  = 16;
	localparam int SEQ_W   = 32;
	localparam int CFG_W   = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_VOTE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DUMP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Word index of the slots_in_use register (byte address 0).
	localparam logic [PADDR_W-3:0] REG_SLOTS_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0]   CFG_RESET        = 5'd16;

	localparam logic [HITS_W-1:0] HITS_ONE = 16'd1;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [HITS_W-1:0] hits;
		logic [SEQ_W-1:0]  birth;
	} slot_t;

	localparam int SLOT_BITS = $bits(slot_t);

endpackage

### hw/rtl/lfu_item_if.sv
// ----------------------------------------------------------------------------
// lfu_item_if
// Command channel of the LFU slot table: a valid/ready beat carries a command
// and the key it concerns.
// ----------------------------------------------------------------------------
interface lfu_item_if;
	logic                       valid;
	logic                       ready;
	logic [lfu_pkg::CMD_W-1:0]  cmd;
	logic [lfu_pkg::KEY_W-1:0]  candidate_key;

	modport source (output valid, output cmd, output candidate_key, input ready);
	modport sink   (input valid, input cmd, input candidate_key, output ready);
endinterface

### hw/rtl/lfu_result_if.sv
// ----------------------------------------------------------------------------
// lfu_result_if
// Result channel of the LFU slot table: a beat per dumped key, one if none.
// ----------------------------------------------------------------------------
interface lfu_result_if;
	logic                       valid;
	logic                       ready;
	logic [lfu_pkg::KEY_W-1:0]  resident_key;
	logic                       present;
	logic                       last;

	modport source (output valid, output resident_key, output present, output last,
		input ready);
	modport sink   (input valid, input resident_key, input present, input last,
		output ready);
endinterface

### hw/rtl/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lfu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/lfu_slot_table_with_age_tiebreak.sv
// ----------------------------------------------------------------------------
// lfu_slot_table_with_age_tiebreak
// LFU slot table with oldest-insertion tie break. Slot keys, hit counts and
// birth stamps live in one slot memory; valid bits are flip-flops.
// ----------------------------------------------------------------------------
// A vote reads every slot once, one a cycle; a miss adds a write-back of the
// new key.
// A dump makes one full pass over the slot memory per resident key to pick the
// next larger key, and a single pass for the single result of an empty table.
// A clear needs no scan.
// Reset empties the table, zeroes the vote sequence and sets slots_in_use to 16.
module lfu_slot_table_with_age_tiebreak #(
	parameter int SLOTS    = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lfu_item_if.sink                     item,
	lfu_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lfu_pkg::PADDR_W-1:0]  paddr,
	input  logic [lfu_pkg::PDATA_W-1:0]  pwdata,
	output logic [lfu_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int USED_W = $clog2(SLOTS + 1);
	localparam int CMP_W  = (USED_W > lfu_pkg::CFG_W) ? USED_W : lfu_pkg::CFG_W;
	localparam int KW     = lfu_pkg::KEY_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [KW-1:0] KEY_MASK = (KEY_BITS >= KW) ? {KW{1'b1}}
		: KW'((64'd1 << KEY_BITS) - 64'd1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_VSCAN = 3'd1;
	localparam logic [2:0] ST_VWRITE = 3'd2;
	localparam logic [2:0] ST_DSCAN = 3'd3;
	localparam logic [2:0] ST_DEMIT = 3'd4;

	logic [2:0]                    state_q;
	logic [KW-1:0]                 key_q;
	logic [lfu_pkg::SEQ_W-1:0]     stamp_q;
	logic [lfu_pkg::SEQ_W-1:0]     seq_q;
	logic [lfu_pkg::CFG_W-1:0]     cfg_q;
	logic [SLOTS-1:0]              valid_q;
	logic [IDX_W-1:0]              cnt_q;
	logic                          issue_q;
	logic                          rd_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic [USED_W-1:0]             used_q;
	logic                          hit_q;
	logic                          free_found_q;
	logic [IDX_W-1:0]              free_idx_q;
	logic                          vic_found_q;
	logic [IDX_W-1:0]              vic_idx_q;
	logic [lfu_pkg::HITS_W-1:0]    vic_hits_q;
	logic [lfu_pkg::SEQ_W-1:0]     vic_birth_q;
	logic                          best_found_q;
	logic [KW-1:0]                 best_key_q;
	logic [KW-1:0]                 prev_key_q;
	logic                          first_q;
	logic [USED_W-1:0]             emitted_q;
	logic                          out_valid_q;
	logic [KW-1:0]                 out_key_q;
	logic                          out_present_q;
	logic                          out_last_q;

	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	lfu_pkg::slot_t                ram_wword;
	logic [lfu_pkg::SLOT_BITS-1:0] ram_rdata;
	lfu_pkg::slot_t                rd_word;

	logic                          accept;
	logic                          cfg_write;
	logic                          cur_valid;
	logic                          end_scan;
	logic                          is_hit;
	logic                          better_vic;
	logic                          better_key;
	logic [lfu_pkg::HITS_W-1:0]    hits_inc;
	logic [CMP_W-1:0]              cfg_ext;
	logic [CMP_W-1:0]              lim;
	logic                          table_full;
	logic [IDX_W-1:0]              target;
	logic                          out_free;
	logic                          dump_last;
	logic [USED_W-1:0]             used_inc;
	logic [USED_W-1:0]             emitted_inc;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr[lfu_pkg::PADDR_W-1:2] == lfu_pkg::REG_SLOTS_IN_USE);
	assign prdata    = (paddr[lfu_pkg::PADDR_W-1:2] == lfu_pkg::REG_SLOTS_IN_USE)
		? lfu_pkg::PDATA_W'(cfg_q) : '0;

	assign item.ready          = (state_q == ST_IDLE);
	assign accept              = item.valid && item.ready;
	assign result.valid        = out_valid_q;
	assign result.resident_key = out_key_q;
	assign result.present      = out_present_q;
	assign result.last         = out_last_q;

	lfu_ram #(
		.WIDTH(lfu_pkg::SLOT_BITS),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wword),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		rd_word   = lfu_pkg::slot_t'(ram_rdata);
		cur_valid = valid_q[idx_s1];
		end_scan  = rd_s1 && (idx_s1 == LAST_IDX);
		is_hit    = (state_q == ST_VSCAN) && rd_s1 && cur_valid && (rd_word.key == key_q);
		hits_inc  = (rd_word.hits == {lfu_pkg::HITS_W{1'b1}}) ? rd_word.hits
			: rd_word.hits + lfu_pkg::HITS_ONE;
		// Lowest count wins, then the oldest birth; equal pairs keep the lower index.
		better_vic = cur_valid && (!vic_found_q || (rd_word.hits < vic_hits_q)
			|| ((rd_word.hits == vic_hits_q) && (rd_word.birth < vic_birth_q)));
		better_key = cur_valid && (first_q || (rd_word.key > prev_key_q))
			&& (!best_found_q || (rd_word.key < best_key_q));

		cfg_ext = CMP_W'(cfg_q);
		if (cfg_q == '0) begin
			lim = CMP_W'(1);
		end else if (cfg_ext > CMP_W'(SLOTS)) begin
			lim = CMP_W'(SLOTS);
		end else begin
			lim = cfg_ext;
		end
		table_full = (CMP_W'(used_q) >= lim) || !free_found_q;
		target     = table_full ? vic_idx_q : free_idx_q;

		out_free    = !out_valid_q || result.ready;
		used_inc    = used_q + USED_W'(1);
		emitted_inc = emitted_q + USED_W'(1);
		dump_last   = (emitted_inc == used_q);

		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wword = '{key: rd_word.key, hits: hits_inc, birth: rd_word.birth};
		if (is_hit) begin
			ram_we = 1'b1;
		end else if (state_q == ST_VWRITE) begin
			ram_we    = 1'b1;
			ram_waddr = target;
			ram_wword = '{key: key_q, hits: lfu_pkg::HITS_ONE, birth: stamp_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			key_q         <= '0;
			stamp_q       <= '0;
			seq_q         <= '0;
			cfg_q         <= lfu_pkg::CFG_RESET;
			valid_q       <= '0;
			cnt_q         <= '0;
			issue_q       <= 1'b0;
			rd_s1         <= 1'b0;
			idx_s1        <= '0;
			used_q        <= '0;
			hit_q         <= 1'b0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			vic_found_q   <= 1'b0;
			vic_idx_q     <= '0;
			vic_hits_q    <= '0;
			vic_birth_q   <= '0;
			best_found_q  <= 1'b0;
			best_key_q    <= '0;
			prev_key_q    <= '0;
			first_q       <= 1'b0;
			emitted_q     <= '0;
			out_valid_q   <= 1'b0;
			out_key_q     <= '0;
			out_present_q <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				cfg_q <= pwdata[lfu_pkg::CFG_W-1:0];
			end
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			// Read issue shared by the vote and dump passes.
			rd_s1  <= issue_q;
			idx_s1 <= cnt_q;
			if (issue_q) begin
				if (cnt_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.cmd)
							lfu_pkg::CMD_VOTE: begin
								key_q        <= item.candidate_key & KEY_MASK;
								stamp_q      <= seq_q;
								if (seq_q != {lfu_pkg::SEQ_W{1'b1}}) begin
									seq_q <= seq_q + lfu_pkg::SEQ_W'(1);
								end
								cnt_q        <= '0;
								issue_q      <= 1'b1;
								used_q       <= '0;
								hit_q        <= 1'b0;
								free_found_q <= 1'b0;
								vic_found_q  <= 1'b0;
								state_q      <= ST_VSCAN;
							end
							lfu_pkg::CMD_DUMP: begin
								cnt_q        <= '0;
								issue_q      <= 1'b1;
								used_q       <= '0;
								best_found_q <= 1'b0;
								first_q      <= 1'b1;
								emitted_q    <= '0;
								state_q      <= ST_DSCAN;
							end
							lfu_pkg::CMD_CLEAR: begin
								valid_q <= '0;
								seq_q   <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_VSCAN: begin
					if (rd_s1) begin
						if (cur_valid) begin
							used_q <= used_inc;
							if (is_hit) begin
								hit_q <= 1'b1;
							end
							if (better_vic) begin
								vic_found_q <= 1'b1;
								vic_idx_q   <= idx_s1;
								vic_hits_q  <= rd_word.hits;
								vic_birth_q <= rd_word.birth;
							end
						end else if (!free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_s1;
						end
					end
					if (end_scan) begin
						state_q <= (hit_q || is_hit) ? ST_IDLE : ST_VWRITE;
					end
				end
				ST_VWRITE: begin
					valid_q[target] <= 1'b1;
					state_q         <= ST_IDLE;
				end
				ST_DSCAN: begin
					if (rd_s1) begin
						// The first pass also counts the resident keys.
						if (first_q && cur_valid) begin
							used_q <= used_inc;
						end
						if (better_key) begin
							best_found_q <= 1'b1;
							best_key_q   <= rd_word.key;
						end
					end
					if (end_scan) begin
						state_q <= ST_DEMIT;
					end
				end
				ST_DEMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (!best_found_q) begin
							out_key_q     <= '0;
							out_present_q <= 1'b0;
							out_last_q    <= 1'b1;
							state_q       <= ST_IDLE;
						end else begin
							out_key_q     <= best_key_q;
							out_present_q <= 1'b1;
							out_last_q    <= dump_last;
							if (dump_last) begin
								state_q <= ST_IDLE;
							end else begin
								prev_key_q   <= best_key_q;
								emitted_q    <= emitted_inc;
								best_found_q <= 1'b0;
								first_q      <= 1'b0;
								cnt_q        <= '0;
								issue_q      <= 1'b1;
								state_q      <= ST_DSCAN;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A dump only reads the slot memory.
	a_dump_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSCAN || state_q == ST_DEMIT) |-> !ram_we)
		else $error("slot memory written during a dump");

	// The resident count never exceeds the number of slots.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(used_q) <= CMP_W'(SLOTS))
		else $error("resident count above slot count");

	// An insertion always leaves at least one resident slot.
	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VWRITE) |=> (valid_q != '0))
		else $error("insertion left the table empty");

	// The empty-table beat is always the last beat of its dump.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_present_q) |-> out_last_q)
		else $error("empty-table beat without last");

	// No new command is taken while a slot scan still has reads outstanding.
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(issue_q || rd_s1) |-> !item.ready)
		else $error("command accepted during a slot scan");

endmodule

### bench/tb_lfu_slot_table_with_age_tiebreak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfu_slot_table_with_age_tiebreak
// Self-checking bench for the LFU slot table. Commands are driven from a queue
// with random gaps. A shadow table predicts every dump beat, and each result
// beat is checked against the oldest prediction while the result side stalls
// at random. The run moves through several slot limits, including the
// extremes and limits that fall below the current fill.
// ----------------------------------------------------------------------------
module tb_lfu_slot_table_with_age_tiebreak;

	localparam int SLOTS         = 16;
	localparam int KEY_BITS      = 16;
	localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
	localparam int POOL_SIZE     = 20;
	localparam logic [lfu_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [lfu_pkg::CMD_W-1:0] cmd;
		logic [lfu_pkg::KEY_W-1:0] key;
		int                        gap;
	} cmd_beat_t;

	typedef struct {
		logic [lfu_pkg::KEY_W-1:0] key;
		logic                      present;
		logic                      last;
	} dump_beat_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [lfu_pkg::PADDR_W-1:0]   paddr;
	logic [lfu_pkg::PDATA_W-1:0]   pwdata;
	logic [lfu_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;

	lfu_item_if   item_bus ();
	lfu_result_if result_bus ();

	lfu_slot_table_with_age_tiebreak #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the slot table.
	logic [lfu_pkg::KEY_W-1:0]  tbl_key   [SLOTS];
	logic [lfu_pkg::HITS_W-1:0] tbl_hits  [SLOTS];
	logic [lfu_pkg::SEQ_W-1:0]  tbl_birth [SLOTS];
	bit                         tbl_valid [SLOTS];
	logic [lfu_pkg::SEQ_W-1:0]  vote_seq;
	logic [lfu_pkg::CFG_W-1:0]  limit_reg;

	cmd_beat_t  cmd_queue [$];
	dump_beat_t dump_beats_due [$];

	int  tx_gap_max;
	int  rx_stall_max;
	int  gap_count;
	int  stall_left;
	bit  cmd_fire;
	bit  res_fire;
	int  mismatches;
	int  votes_seen;
	int  dumps_seen;
	int  clears_seen;
	int  beats_checked;
	int  limits_tried;
	logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

	always #5 clk = ~clk;

	initial begin
		clk                        = 1'b0;
		arst_n                     = 1'b0;
		psel                       = 1'b0;
		penable                    = 1'b0;
		pwrite                     = 1'b0;
		paddr                      = '0;
		pwdata                     = '0;
		item_bus.valid             = 1'b0;
		item_bus.cmd               = lfu_pkg::CMD_VOTE;
		item_bus.candidate_key     = '0;
		result_bus.ready           = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i]   = '0;
			tbl_hits[i]  = '0;
			tbl_birth[i] = '0;
		end
		vote_seq      = '0;
		limit_reg     = lfu_pkg::CFG_RESET;
		tx_gap_max    = 0;
		rx_stall_max  = 0;
		gap_count     = 0;
		stall_left    = 0;
		cmd_fire      = 1'b0;
		res_fire      = 1'b0;
		mismatches    = 0;
		votes_seen    = 0;
		dumps_seen    = 0;
		clears_seen   = 0;
		beats_checked = 0;
		limits_tried  = 1;
	end

	task automatic predict_vote(input logic [lfu_pkg::KEY_W-1:0] key);
		logic [lfu_pkg::SEQ_W-1:0] stamp;
		int                        used;
		int                        victim;
		int                        free_slot;
		int                        lim;
		int                        target;
		bit                        hit;
		stamp = vote_seq;
		if (vote_seq != {lfu_pkg::SEQ_W{1'b1}})
			vote_seq = vote_seq + 1'b1;
		used      = 0;
		victim    = -1;
		free_slot = -1;
		hit       = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!tbl_valid[i]) begin
				if (free_slot < 0)
					free_slot = i;
			end else begin
				used++;
				// The hit count is raised before this slot competes as a victim.
				if (tbl_key[i] == key) begin
					if (tbl_hits[i] != {lfu_pkg::HITS_W{1'b1}})
						tbl_hits[i] = tbl_hits[i] + 1'b1;
					hit = 1'b1;
				end
				if (victim < 0 || tbl_hits[i] < tbl_hits[victim] ||
						(tbl_hits[i] == tbl_hits[victim] &&
						tbl_birth[i] < tbl_birth[victim]))
					victim = i;
			end
		end
		if (!hit) begin
			lim = limit_reg;
			if (lim < 1)
				lim = 1;
			if (lim > SLOTS)
				lim = SLOTS;
			target = (used >= lim || free_slot < 0) ? victim : free_slot;
			if (target >= 0) begin
				tbl_key[target]   = key;
				tbl_hits[target]  = lfu_pkg::HITS_ONE;
				tbl_birth[target] = stamp;
				tbl_valid[target] = 1'b1;
			end
		end
	endtask

	task automatic lfu_predict(input logic [lfu_pkg::CMD_W-1:0] op,
			input logic [lfu_pkg::KEY_W-1:0] key);
		logic [lfu_pkg::KEY_W-1:0] sorted_keys [SLOTS];
		logic [lfu_pkg::KEY_W-1:0] k;
		int                        n;
		int                        j;
		dump_beat_t                beat;
		case (op)
			lfu_pkg::CMD_VOTE: begin
				votes_seen++;
				predict_vote(key);
			end
			lfu_pkg::CMD_DUMP: begin
				dumps_seen++;
				n = 0;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_valid[i]) begin
						k = tbl_key[i];
						j = n;
						while (j > 0 && sorted_keys[j - 1] > k) begin
							sorted_keys[j] = sorted_keys[j - 1];
							j--;
						end
						sorted_keys[j] = k;
						n++;
					end
				end
				if (n == 0) begin
					beat.key     = '0;
					beat.present = 1'b0;
					beat.last    = 1'b1;
					dump_beats_due = {dump_beats_due, beat};
				end else begin
					for (int i = 0; i < n; i++) begin
						beat.key     = sorted_keys[i];
						beat.present = 1'b1;
						beat.last    = (i == n - 1);
						dump_beats_due = {dump_beats_due, beat};
					end
				end
			end
			lfu_pkg::CMD_CLEAR: begin
				clears_seen++;
				for (int i = 0; i < SLOTS; i++)
					tbl_valid[i] = 1'b0;
				vote_seq = '0;
			end
			default: begin
			end
		endcase
	endtask

	// Accepted command beats feed the predictor; result beats are checked.
	always @(posedge clk) begin : monitor
		dump_beat_t want;
		if (arst_n) begin
			if (item_bus.valid && item_bus.ready)
				lfu_predict(item_bus.cmd, item_bus.candidate_key);
			if (result_bus.valid && result_bus.ready) begin
				beats_checked++;
				if (dump_beats_due.size() == 0) begin
					$error("result beat with no dump pending: resident_key %h",
						result_bus.resident_key);
					mismatches++;
				end else begin
					want = dump_beats_due.pop_front();
					if (result_bus.resident_key !== want.key) begin
						$error("resident_key: expected %h, got %h",
							want.key, result_bus.resident_key);
						mismatches++;
					end
					if (result_bus.present !== want.present) begin
						$error("present: expected %b, got %b",
							want.present, result_bus.present);
						mismatches++;
					end
					if (result_bus.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, result_bus.last);
						mismatches++;
					end
				end
			end
		end
		cmd_fire <= arst_n && item_bus.valid && item_bus.ready;
		res_fire <= arst_n && result_bus.valid && result_bus.ready;
	end

	always @(negedge clk) begin : cmd_driver
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
		end else if (!item_bus.valid || cmd_fire) begin
			if (cmd_queue.size() != 0 && gap_count >= cmd_queue[0].gap) begin
				item_bus.valid         <= 1'b1;
				item_bus.cmd           <= cmd_queue[0].cmd;
				item_bus.candidate_key <= cmd_queue[0].key;
				void'(cmd_queue.pop_front());
				gap_count = 0;
			end else begin
				item_bus.valid <= 1'b0;
				if (cmd_queue.size() != 0)
					gap_count++;
			end
		end
	end

	always @(negedge clk) begin : result_sink
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (res_fire)
				stall_left = $urandom_range(rx_stall_max, 0);
			if (stall_left > 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	task automatic queue_cmd(input logic [lfu_pkg::CMD_W-1:0] op,
			input logic [lfu_pkg::KEY_W-1:0] key);
		cmd_beat_t beat;
		beat.cmd = op;
		beat.key = key;
		beat.gap = $urandom_range(tx_gap_max, 0);
		cmd_queue = {cmd_queue, beat};
	endtask

	// Holds off until every queued command is taken and every dump beat has
	// arrived, then lets a vote that was still scanning run to completion.
	task automatic wait_table_idle();
		do
			@(posedge clk);
		while (cmd_queue.size() != 0 || item_bus.valid || dump_beats_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [lfu_pkg::CFG_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {lfu_pkg::REG_SLOTS_IN_USE, 2'b00};
		pwdata  <= lfu_pkg::PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		limit_reg = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		limits_tried++;
	endtask

	// Mostly votes drawn from a small key set so that hits, fills and
	// evictions all happen; a dump always closes the phase.
	task automatic random_phase(input logic [lfu_pkg::CFG_W-1:0] limit, input int n_items,
			input int gap_max, input int stall_max);
		int                        taken;
		int                        r;
		logic [lfu_pkg::KEY_W-1:0] key;
		tx_gap_max   = gap_max;
		rx_stall_max = stall_max;
		write_limit(limit);
		key_pool[0] = '0;
		key_pool[1] = {lfu_pkg::KEY_W{1'b1}};
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = lfu_pkg::KEY_W'($urandom);
		taken = 0;
		while (taken < n_items) begin
			r = $urandom_range(99, 0);
			if ($urandom_range(99, 0) < 85)
				key = key_pool[$urandom_range(POOL_SIZE - 1, 0)];
			else
				key = lfu_pkg::KEY_W'($urandom);
			if (r < 5) begin
				queue_cmd(CMD_UNUSED, key);
			end else begin
				taken++;
				if (r < 20)
					queue_cmd(lfu_pkg::CMD_DUMP, key);
				else if (r < 23)
					queue_cmd(lfu_pkg::CMD_CLEAR, key);
				else
					queue_cmd(lfu_pkg::CMD_VOTE, key);
			end
		end
		queue_cmd(lfu_pkg::CMD_DUMP, lfu_pkg::KEY_W'($urandom));
		wait_table_idle();
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset limit: empty dump, unused command, key extremes, a hit, clear.
		tx_gap_max   = 3;
		rx_stall_max = 3;
		queue_cmd(lfu_pkg::CMD_DUMP, 16'hA5A5);
		queue_cmd(CMD_UNUSED, 16'h1357);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h0000);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'hFFFF);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h8000);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h0000);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h1234);
		queue_cmd(lfu_pkg::CMD_DUMP, 16'h0000);
		queue_cmd(lfu_pkg::CMD_CLEAR, 16'hFFFF);
		queue_cmd(lfu_pkg::CMD_DUMP, 16'h5A5A);
		wait_table_idle();

		// Two slots: the oldest of equal counts goes first, then the lowest count.
		write_limit(5'd2);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h0011);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h0022);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h0033);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h0022);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h0044);
		queue_cmd(lfu_pkg::CMD_DUMP, 16'h0000);
		wait_table_idle();

		// A limit of zero acts as one, and it is below the current fill.
		write_limit(5'd0);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h0005);
		queue_cmd(lfu_pkg::CMD_VOTE, 16'h0006);
		queue_cmd(lfu_pkg::CMD_DUMP, 16'h0000);
		wait_table_idle();

		random_phase(5'd31, 20, 0, 0);
		random_phase(5'd16, 10, 13, 13);
		random_phase(5'd1, 8, 13, 0);
		random_phase(5'd17, 8, 0, 13);
		random_phase(5'd5, 8, 6, 9);
		random_phase(5'd8, 8, 13, 13);
		random_phase(5'd3, 8, 2, 5);
		random_phase(5'd16, 8, 0, 0);

		$display("Ran %0d votes, %0d dumps and %0d clears under %0d slot limits;",
			votes_seen, dumps_seen, clears_seen, limits_tried);
		$display("checked %0d dump beats with %0d mismatches.", beats_checked, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_item_if.sv
hw/rtl/lfu_result_if.sv
hw/rtl/lfu_ram.sv
hw/rtl/lfu_slot_table_with_age_tiebreak.sv
bench/tb_lfu_slot_table_with_age_tiebreak.sv
